/* rtl/ngh_pkg.sv */
// shared types and constants for the noise gate with hysteresis
package ngh_pkg;

  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_CLOSE_LEVEL   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OPEN_LEVEL    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK_COEFF  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_COEFF = 2'd3;

  localparam logic [31:0] ATTACK_COEFF_RST  = 32'd16609444;
  localparam logic [31:0] RELEASE_COEFF_RST = 32'd16773720;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_UPD,
    ST_GATE
  } ngh_state_t;

  typedef struct packed {
    logic load_in;
    logic mul_env;
    logic upd_env;
    logic load_out;
  } ngh_cmd_t;

endpackage

/* rtl/ngh_if.sv */
// request channel interfaces for sample input and gated result
interface ngh_in_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

interface ngh_out_if #(
  parameter int SAMPLE_BITS    = 24,
  parameter int GAIN_FRAC_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic [GAIN_FRAC_BITS:0]       gain_level;

  modport source (output valid, output sample_out, output gain_level, input ready);
  modport sink (input valid, input sample_out, input gain_level, output ready);
endinterface

/* rtl/noise_gate_hysteresis_envelope_top.sv */
// top level of the noise gate with hysteresis and shared gain envelope
//
//   channel   dir   handshake          payload
//   in_chan   in    valid / ready      sample_in
//   out_chan  out   valid / ready      sample_out, gain_level
//   cfg_*     in    write enable only  cfg_index, cfg_data
//
// a request runs through these steps in order: accept with level compare, envelope multiply,
// envelope update, gate multiply into the output register
// the next request is taken while a result waits in the output register
// a stalled output holds the gate step until the register frees
// synchronous active-low reset closes the gate and loads default coefficients
module noise_gate_hysteresis_envelope_top
  import ngh_pkg::*;
#(
  parameter int SAMPLE_BITS    = 24,
  parameter int GAIN_FRAC_BITS = 24
) (
  input  logic                 clk,
  input  logic                 rst_n,
  ngh_in_if.sink               in_chan,
  ngh_out_if.source            out_chan,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [((SAMPLE_BITS > GAIN_FRAC_BITS) ? SAMPLE_BITS : GAIN_FRAC_BITS)-1:0] cfg_data
);

  localparam int CFG_W = (SAMPLE_BITS > GAIN_FRAC_BITS) ? SAMPLE_BITS : GAIN_FRAC_BITS;

  ngh_cmd_t cmd;

  ngh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd)
  );

  ngh_dp #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
    .CFG_W          (CFG_W)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .sample_in  (in_chan.sample_in),
    .sample_out (out_chan.sample_out),
    .gain_level (out_chan.gain_level)
  );

endmodule

/* rtl/ngh_ctrl.sv */
// sequencer for one request: compare, envelope multiply, update, gate
module ngh_ctrl
  import ngh_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output ngh_cmd_t cmd
);

  ngh_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul_env = 1'b1;
        state_nxt   = ST_UPD;
      end
      ST_UPD: begin
        cmd.upd_env = 1'b1;
        state_nxt   = ST_GATE;
      end
      ST_GATE: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* rtl/ngh_dp.sv */
// datapath: level registers, envelope state, envelope and gate multipliers
module ngh_dp
  import ngh_pkg::*;
#(
  parameter int SAMPLE_BITS    = 24,
  parameter int GAIN_FRAC_BITS = 24,
  parameter int CFG_W          = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_W-1:0]              cfg_data,
  input  ngh_cmd_t                      cmd,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  output logic signed [SAMPLE_BITS-1:0] sample_out,
  output logic [GAIN_FRAC_BITS:0]       gain_level
);

  localparam int S = SAMPLE_BITS;
  localparam int G = GAIN_FRAC_BITS;
  localparam logic [G:0] GAIN_ONE = {1'b1, {G{1'b0}}};

  logic [S-1:0]          close_level_r, open_level_r;
  logic [G-1:0]          attack_coeff_r, release_coeff_r;
  logic [G:0]            env_r;
  logic signed [S-1:0]   sample_r;
  logic                  rise_r, decay_r;
  logic [2*G:0]          eprod_r;
  logic signed [S-1:0]   sample_out_r;
  logic [G:0]            gain_level_r;

  logic [S-1:0]          mag;
  logic                  rise, decay;
  logic [G-1:0]          coeff_sel;
  logic [G:0]            env_scaled;
  logic [G:0]            attack_gap;
  logic [G:0]            env_nxt;
  logic signed [S+G:0]   gate_prod;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      close_level_r   <= '0;
      open_level_r    <= '0;
      attack_coeff_r  <= ATTACK_COEFF_RST[G-1:0];
      release_coeff_r <= RELEASE_COEFF_RST[G-1:0];
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CLOSE_LEVEL:   close_level_r   <= cfg_data[S-1:0];
        REG_OPEN_LEVEL:    open_level_r    <= cfg_data[S-1:0];
        REG_ATTACK_COEFF:  attack_coeff_r  <= cfg_data[G-1:0];
        REG_RELEASE_COEFF: release_coeff_r <= cfg_data[G-1:0];
        default: ;
      endcase
    end
  end

  // magnitude of the most negative sample is 2^(S-1), still fits unsigned
  assign mag   = sample_in[S-1] ? (~sample_in + 1'b1) : sample_in;
  assign rise  = mag > open_level_r;
  assign decay = !rise && (mag < close_level_r);

  assign coeff_sel  = rise_r ? attack_coeff_r : release_coeff_r;
  assign env_scaled = eprod_r[2*G:G];
  assign attack_gap = GAIN_ONE - {1'b0, attack_coeff_r};

  always_comb begin
    env_nxt = env_r;
    if (rise_r) begin
      env_nxt = env_scaled + attack_gap;
    end else if (decay_r) begin
      env_nxt = env_scaled;
    end
  end

  assign gate_prod = sample_r * $signed({1'b0, env_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      env_r <= '0;
    end else if (cmd.upd_env) begin
      env_r <= env_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      sample_r <= sample_in;
      rise_r   <= rise;
      decay_r  <= decay;
    end
    if (cmd.mul_env) begin
      eprod_r <= env_r * coeff_sel;
    end
    if (cmd.load_out) begin
      // dropping the low bits of the signed product floors toward minus infinity
      sample_out_r <= gate_prod[S+G-1:G];
      gain_level_r <= env_r;
    end
  end

  assign sample_out = sample_out_r;
  assign gain_level = gain_level_r;

endmodule

/* tb/tb_top.sv */
// self-checking testbench for the noise gate with hysteresis envelope
`timescale 1ns / 1ps

module tb_top;
  import ngh_pkg::*;

  localparam int SB = 24;
  localparam int GF = 24;
  localparam int STALL_LIMIT = 1000;
  localparam int LONG_HOLD = 120;

  class gate_scoreboard;
    typedef struct {
      logic signed [SB-1:0] sample;
      logic [GF:0]          gain;
    } gated_t;

    logic [SB-1:0] close_lvl;
    logic [SB-1:0] open_lvl;
    logic [GF-1:0] attack_k;
    logic [GF-1:0] release_k;
    logic [GF:0]   envelope;
    gated_t        gated_q[$];
    int unsigned   mismatches;

    function new();
      close_lvl  = '0;
      open_lvl   = '0;
      attack_k   = ATTACK_COEFF_RST[GF-1:0];
      release_k  = RELEASE_COEFF_RST[GF-1:0];
      envelope   = '0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [SB-1:0] val);
      case (idx)
        REG_CLOSE_LEVEL:   close_lvl = val;
        REG_OPEN_LEVEL:    open_lvl = val;
        REG_ATTACK_COEFF:  attack_k = val;
        REG_RELEASE_COEFF: release_k = val;
        default: ;
      endcase
    endfunction

    function void note_sample(logic signed [SB-1:0] s);
      logic [SB-1:0] mag;
      logic [63:0]   acc;
      longint        prod;
      gated_t        g;
      mag = s[SB-1] ? (SB'(0) - s) : s;
      if (mag > open_lvl) begin
        acc = (64'(envelope) * 64'(attack_k)) >> GF;
        acc = acc + (64'd1 << GF) - 64'(attack_k);
        envelope = acc[GF:0];
      end else if (mag < close_lvl) begin
        acc = (64'(envelope) * 64'(release_k)) >> GF;
        envelope = acc[GF:0];
      end
      prod = longint'(s) * longint'(envelope);
      prod = prod >>> GF;
      g.sample = prod[SB-1:0];
      g.gain   = envelope;
      gated_q.push_back(g);
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch on %s: got %0h, expected %0h", what, got, want);
      mismatches++;
    endtask

    task check_gated(logic signed [SB-1:0] s, logic [GF:0] g);
      gated_t want;
      if (gated_q.size() == 0) begin
        report_mismatch("unexpected result", 64'(s), 64'(0));
      end else begin
        want = gated_q.pop_front();
        if (s !== want.sample) report_mismatch("sample_out", 64'(s), 64'(want.sample));
        if (g !== want.gain) report_mismatch("gain_level", 64'(g), 64'(want.gain));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [SB-1:0] cfg_data;

  bit idling_on;
  int unsigned long_hold_req = 0;
  int unsigned quiet_cycles = 0;

  gate_scoreboard gate_sb = new();

  ngh_in_if #(.SAMPLE_BITS(SB)) in_if ();
  ngh_out_if #(.SAMPLE_BITS(SB), .GAIN_FRAC_BITS(GF)) out_if ();

  noise_gate_hysteresis_envelope_top #(
    .SAMPLE_BITS(SB),
    .GAIN_FRAC_BITS(GF)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_chan(in_if),
    .out_chan(out_if),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      gate_sb.check_gated(out_if.sample_out, out_if.gain_level);
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side: random stalls plus one long hold-off
  initial begin
    int unsigned holds_done;
    holds_done = 0;
    out_if.ready <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (long_hold_req != holds_done) begin
        holds_done = long_hold_req;
        out_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (idling_on && $urandom_range(0, 3) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        out_if.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  task send_sample(input logic signed [SB-1:0] s);
    in_if.valid <= 1'b1;
    in_if.sample_in <= s;
    do @(posedge clk); while (!(in_if.valid && in_if.ready));
    gate_sb.note_sample(s);
    if (idling_on && $urandom_range(0, 2) == 0) begin
      in_if.valid <= 1'b0;
      in_if.sample_in <= SB'($urandom);
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SB-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    gate_sb.set_reg(idx, val);
  endtask

  task program_gate(input logic [SB-1:0] close_v, input logic [SB-1:0] open_v,
                    input logic [GF-1:0] atk_v, input logic [GF-1:0] rel_v);
    write_reg(REG_CLOSE_LEVEL, close_v);
    write_reg(REG_OPEN_LEVEL, open_v);
    write_reg(REG_ATTACK_COEFF, atk_v);
    write_reg(REG_RELEASE_COEFF, rel_v);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task drain_results;
    in_if.valid <= 1'b0;
    while (gate_sb.gated_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [SB-1:0] pick_level();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return SB'($urandom);
      2: return SB'($urandom_range(0, 4096));
      3: return SB'(1 << (SB - 1));
      default: return SB'($urandom_range(0, 1 << (SB - 1)));
    endcase
  endfunction

  function automatic logic [GF-1:0] pick_coeff();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return GF'($urandom);
      default: return GF'((1 << GF) - 1 - $urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic signed [SB-1:0] near_level(logic [SB-1:0] lvl);
    int m;
    m = int'(lvl) + int'($urandom_range(0, 32)) - 16;
    if (m < 0) m = 0;
    if (m > (1 << (SB - 1))) m = 1 << (SB - 1);
    if ($urandom_range(0, 1)) return SB'(-m);
    if (m > (1 << (SB - 1)) - 1) m = (1 << (SB - 1)) - 1;
    return SB'(m);
  endfunction

  function automatic logic signed [SB-1:0] pick_sample();
    case ($urandom_range(0, 6))
      0, 1: return SB'($urandom);
      2, 3: return near_level(gate_sb.open_lvl);
      4: return near_level(gate_sb.close_lvl);
      5: begin
        case ($urandom_range(0, 4))
          0: return SB'((1 << (SB - 1)) - 1);
          1: return SB'(1 << (SB - 1));
          2: return '0;
          3: return '1;
          default: return SB'(1);
        endcase
      end
      default: return SB'($signed($urandom_range(0, 511)) - 256);
    endcase
  endfunction

  logic signed [SB-1:0] run_reset[] = '{0, 8388607, -8388608, -1, 1, 0};
  logic signed [SB-1:0] run_bands[] = '{3000000, 1500000, -8388608, 100, -2097152,
                                        2097153, -1048576, -1048575};
  logic signed [SB-1:0] run_crossed[] = '{5000, 50, 8388607, -8388608};
  logic signed [SB-1:0] run_shut[] = '{8388607, -8388608, 0};

  initial begin
    logic [SB-1:0] lvl_a;
    logic [SB-1:0] lvl_b;
    idling_on = 1'b1;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_if.valid <= 1'b0;
    in_if.sample_in <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (run_reset[i]) send_sample(run_reset[i]);
    drain_results();

    // attack and release of zero, hold band between the two levels
    program_gate(SB'(1 << 20), SB'(1 << 21), '0, '0);
    foreach (run_bands[i]) send_sample(run_bands[i]);
    drain_results();

    // crossed levels, rise test wins
    program_gate(SB'(8000000), SB'(100), '1, '1);
    foreach (run_crossed[i]) send_sample(run_crossed[i]);
    drain_results();

    // levels above full scale: never opens, always decays
    program_gate('1, '1, GF'(1 << (GF - 1)), GF'(1 << (GF - 1)));
    foreach (run_shut[i]) send_sample(run_shut[i]);
    drain_results();

    for (int ph = 0; ph < 7; ph++) begin
      lvl_a = pick_level();
      lvl_b = pick_level();
      if (lvl_a > lvl_b && $urandom_range(0, 3) != 0) begin
        program_gate(lvl_b, lvl_a, pick_coeff(), pick_coeff());
      end else begin
        program_gate(lvl_a, lvl_b, pick_coeff(), pick_coeff());
      end
      idling_on = (ph == 6) ? 1'b0 : ($urandom_range(0, 3) != 0);
      if (ph == 2) long_hold_req++;
      repeat (55) send_sample(pick_sample());
      drain_results();
    end

    if (gate_sb.mismatches == 0 && gate_sb.gated_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* noise_gate_hysteresis_envelope_top.f */
rtl/ngh_pkg.sv
rtl/ngh_if.sv
rtl/ngh_ctrl.sv
rtl/ngh_dp.sv
rtl/noise_gate_hysteresis_envelope_top.sv
tb/tb_top.sv
